// ===== rtl/awmd_pkg.sv =====
// Shared types and constants for the ADC word median deglitcher.
// No dependencies; the other rtl files except awmd_cell refer to it by scoped names.
`default_nettype none

package awmd_pkg;

  // Input word layout
  localparam int WORD_W      = 16;
  localparam int OVR1_BIT    = 15;
  localparam int OVR2_BIT    = 14;
  localparam int SAMPLE_BITS = 10;

  // Filter geometry
  localparam int WIN_TAPS    = 4;   // stored raw samples
  localparam int FRAME_LEN   = 5;   // window plus the incoming sample
  localparam int MAX_RESULTS = 5;   // most results one item can release
  localparam int CNT_W       = 3;   // holds 0..MAX_RESULTS
  localparam int QUEUE_DEPTH = 8;

  // Fill count saturates here: five or more samples in the open datagram
  localparam logic [CNT_W-1:0] FILL_SAT  = 3'd5;
  localparam logic [CNT_W-1:0] FILL_FOUR = 3'd4;

  // Result layout
  localparam int LEVEL_OUT_W = 11;
  localparam int NUM_W       = 32;
  localparam int M_TDATA_W   = 48;
  localparam int M_TUSER_W   = 3;

  typedef struct packed {
    logic signed [LEVEL_OUT_W-1:0] level_half_lsb;
    logic                          over_range_one;
    logic                          over_range_two;
    logic [NUM_W-1:0]              sample_number;
    logic                          datagram_end_out;
    logic                          run_last;
  } result_t;

  // Burst of results handed from the frame logic to the output queue
  typedef struct packed {
    logic [CNT_W-1:0]                count;
    result_t [MAX_RESULTS-1:0]       items;
  } push_t;

endpackage

`default_nettype wire

// ===== rtl/awmd_cell.sv =====
// One tap of the raw sample window: a register that takes its neighbor's sample.
// Generic in width; uses no package items.
`default_nettype none

module awmd_cell #(
  parameter int W = 13
) (
  input  wire logic         clk,
  input  wire logic         shift,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/awmd_frame.sv =====
// Word decode, median-of-five / median-of-three evaluation and result selection.
// Depends on awmd_pkg; reads the window taps held by the awmd_cell chain.
`default_nettype none

module awmd_frame #(
  parameter int SAMPLE_BITS = awmd_pkg::SAMPLE_BITS
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   accept,
  input  wire logic [awmd_pkg::WORD_W-1:0]            code_word,
  input  wire logic                                   end_of_datagram,
  input  wire logic [awmd_pkg::WIN_TAPS-1:0][SAMPLE_BITS+2:0] taps,
  output logic      [SAMPLE_BITS+2:0]                 new_smp,
  output awmd_pkg::push_t                             push
);

  localparam int LEVEL_W = SAMPLE_BITS + 1;
  localparam int OUT_W   = awmd_pkg::LEVEL_OUT_W;
  localparam int CW      = awmd_pkg::CNT_W;
  localparam int NW      = awmd_pkg::NUM_W;
  localparam int FL      = awmd_pkg::FRAME_LEN;
  localparam logic [SAMPLE_BITS-1:0] HALF = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [CW-1:0] fill;
  logic [NW-1:0] counter;
  logic [NW-1:0] counter_next;

  logic [SAMPLE_BITS-1:0]   code;
  logic [LEVEL_W-1:0]       code_s;
  logic [LEVEL_W-1:0]       code_m1;
  logic [LEVEL_W-1:0]       new_level;

  // Frame: index k is the sample k items ago, k = 0 being the incoming one
  logic signed [LEVEL_W-1:0] xl [FL];
  logic                      xo1 [FL];
  logic                      xo2 [FL];
  logic signed [LEVEL_W-1:0] fl [FL];
  logic signed [OUT_W-1:0]   fo [FL];
  logic [CW-1:0]             rank [FL];
  logic signed [LEVEL_W-1:0] med5;
  logic signed [LEVEL_W-1:0] m3a;
  logic signed [LEVEL_W-1:0] m3b;

  logic [CW-1:0] n;
  logic          full;
  logic          four;
  logic          emit;
  logic [CW-1:0] khi;
  logic [CW-1:0] klo;
  awmd_pkg::result_t rk [FL];

  function automatic logic signed [LEVEL_W-1:0] med3(
    input logic signed [LEVEL_W-1:0] a,
    input logic signed [LEVEL_W-1:0] b,
    input logic signed [LEVEL_W-1:0] c
  );
    logic signed [LEVEL_W-1:0] lo;
    logic signed [LEVEL_W-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c < lo) begin
      med3 = lo;
    end else if (c > hi) begin
      med3 = hi;
    end else begin
      med3 = c;
    end
  endfunction

  // Decode: codes above half scale wrap negative; level = 2*code-1
  assign code      = code_word[SAMPLE_BITS-1:0];
  assign code_s    = (code > HALF) ? {1'b1, code} : {1'b0, code};
  assign code_m1   = code_s - LEVEL_W'(1);
  assign new_level = {code_m1[SAMPLE_BITS-1:0], 1'b1};
  assign new_smp   = {code_word[awmd_pkg::OVR1_BIT], code_word[awmd_pkg::OVR2_BIT], new_level};

  assign counter_next = counter + NW'(1);

  always_comb begin
    xl[0]  = new_level;
    xo1[0] = code_word[awmd_pkg::OVR1_BIT];
    xo2[0] = code_word[awmd_pkg::OVR2_BIT];
    for (int k = 1; k < FL; k++) begin
      xl[k]  = taps[k-1][LEVEL_W-1:0];
      xo2[k] = taps[k-1][LEVEL_W];
      xo1[k] = taps[k-1][LEVEL_W+1];
    end
  end

  // Median of five by rank: ties broken by position so exactly one rank is two
  always_comb begin
    for (int i = 0; i < FL; i++) begin
      rank[i] = '0;
      for (int j = 0; j < FL; j++) begin
        if (j != i && (xl[j] < xl[i] || (xl[j] == xl[i] && j < i))) begin
          rank[i] = rank[i] + CW'(1);
        end
      end
    end
    med5 = xl[0];
    for (int i = 0; i < FL; i++) begin
      if (rank[i] == CW'(2)) begin
        med5 = xl[i];
      end
    end
  end

  assign m3a = med3(xl[0], xl[1], xl[2]);
  assign m3b = med3(xl[1], xl[2], xl[3]);

  assign full = (fill >= awmd_pkg::FILL_SAT);
  assign four = (fill == awmd_pkg::FILL_FOUR);
  assign n    = (fill >= awmd_pkg::FILL_FOUR) ? awmd_pkg::FILL_FOUR : fill;

  // Filtered levels: center of a full window, inner samples of short datagrams
  always_comb begin
    for (int k = 0; k < FL; k++) begin
      fl[k] = xl[k];
    end
    if (end_of_datagram && (n == CW'(2) || n == CW'(3))) begin
      fl[1] = m3a;
    end
    if (n == awmd_pkg::FILL_FOUR) begin
      fl[2] = med5;
    end else if (end_of_datagram && n == CW'(3)) begin
      fl[2] = m3b;
    end
  end

  for (genvar k = 0; k < FL; k++) begin : g_out_level
    if (LEVEL_W >= OUT_W) begin : g_trunc
      assign fo[k] = fl[k][OUT_W-1:0];
    end else begin : g_sext
      assign fo[k] = {{(OUT_W-LEVEL_W){fl[k][LEVEL_W-1]}}, fl[k]};
    end
  end

  // Release range, oldest first, as frame indices khi down to klo
  always_comb begin
    emit = 1'b1;
    klo  = '0;
    khi  = n;
    if (end_of_datagram) begin
      if (full) begin
        khi = CW'(2);
      end
    end else if (four) begin
      khi = awmd_pkg::FILL_FOUR;
      klo = CW'(2);
    end else if (full) begin
      khi = CW'(2);
      klo = CW'(2);
    end else begin
      emit = 1'b0;
    end
  end

  always_comb begin
    for (int k = 0; k < FL; k++) begin
      rk[k].level_half_lsb   = fo[k];
      rk[k].over_range_one   = xo1[k];
      rk[k].over_range_two   = xo2[k];
      rk[k].sample_number    = counter_next - NW'(k);
      rk[k].datagram_end_out = end_of_datagram && (k == 0);
      rk[k].run_last         = (CW'(k) == klo);
    end
  end

  always_comb begin
    logic [CW-1:0] kidx;
    kidx       = '0;
    push.count = (accept && emit) ? (khi - klo + CW'(1)) : '0;
    for (int j = 0; j < awmd_pkg::MAX_RESULTS; j++) begin
      if (CW'(j) <= khi) begin
        kidx = khi - CW'(j);
      end else begin
        kidx = '0;
      end
      push.items[j] = rk[kidx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      counter <= '0;
    end else if (accept) begin
      counter <= counter_next;
      if (end_of_datagram) begin
        fill <= '0;
      end else if (!full) begin
        fill <= fill + CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/awmd_queue.sv =====
// Output queue: a chain of result cells shifting toward the head, burst-written.
// Depends on awmd_pkg for result_t and push_t.
`default_nettype none

module awmd_queue #(
  parameter int DEPTH = awmd_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire awmd_pkg::push_t   push,
  output logic                   room,
  output logic                   m_valid,
  input  wire logic              m_ready,
  output awmd_pkg::result_t      head
);

  localparam int CW  = $clog2(DEPTH + 1);
  localparam int PCW = awmd_pkg::CNT_W;

  awmd_pkg::result_t q      [DEPTH];
  awmd_pkg::result_t q_next [DEPTH];
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] base;
  logic          pop;

  assign m_valid    = (count != '0);
  assign pop        = m_valid && m_ready;
  assign base       = count - CW'(pop);
  assign count_next = base + CW'(push.count);
  assign room       = (count <= CW'(DEPTH - awmd_pkg::MAX_RESULTS));
  assign head       = q[0];

  for (genvar e = 0; e < DEPTH; e++) begin : g_cell
    always_comb begin
      logic [CW-1:0] off;
      off       = CW'(e) - base;
      q_next[e] = q[e];
      if (CW'(e) < base) begin
        if (pop) begin
          if (e < DEPTH - 1) begin
            q_next[e] = q[(e < DEPTH - 1) ? e + 1 : e];
          end
        end
      end else if (off < CW'(push.count)) begin
        q_next[e] = push.items[off[PCW-1:0]];
      end
    end

    always_ff @(posedge clk) begin
      q[e] <= q_next[e];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/adc_word_median_deglitch.sv =====
// Top level of the ADC word median deglitcher: window cell chain, frame logic, output queue.
// Depends on awmd_pkg, awmd_cell, awmd_frame and awmd_queue.
//
//   channel   direction  beat carries
//   s_axis    in         one ADC word; tlast marks the end of its datagram
//   m_axis    out        one sample result; tlast marks the datagram end
//
// An item is taken every cycle while the output queue has room for a full burst
// of five results (at most QUEUE_DEPTH-5 results waiting); results leave one per
// cycle while m_axis_tready is high, from the head queue cell. The window is four
// cells that shift on every accepted item. Synchronous reset clears the fill count,
// sample counter and queue count; a stall on m_axis only backs up into s_axis_tready.
`default_nettype none

module adc_word_median_deglitch #(
  parameter int SAMPLE_BITS = awmd_pkg::SAMPLE_BITS,
  parameter int QUEUE_DEPTH = awmd_pkg::QUEUE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [awmd_pkg::WORD_W-1:0]     s_axis_tdata,  // [15:0] code_word
  input  wire logic                            s_axis_tlast,  // end_of_datagram
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [10:0] level_half_lsb, [42:11] sample_number, [47:43] zero
  output logic      [awmd_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  output logic                                 m_axis_tlast,  // datagram_end_out
  // [0] over_range_one, [1] over_range_two, [2] run_last
  output logic      [awmd_pkg::M_TUSER_W-1:0]  m_axis_tuser
);

  localparam int SMP_W = SAMPLE_BITS + 3;
  localparam int TAPS  = awmd_pkg::WIN_TAPS;
  localparam int PAD_W = awmd_pkg::M_TDATA_W - awmd_pkg::LEVEL_OUT_W - awmd_pkg::NUM_W;

  logic                        accept;
  logic                        room;
  logic [SMP_W-1:0]            new_smp;
  logic [TAPS-1:0][SMP_W-1:0]  taps;
  awmd_pkg::push_t             push;
  awmd_pkg::result_t           head;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  // Cell 0 takes the decoded incoming sample, each further cell its neighbor's
  for (genvar k = 0; k < TAPS; k++) begin : g_win
    if (k == 0) begin : g_first
      awmd_cell #(.W(SMP_W)) u_cell (
        .clk   (clk),
        .shift (accept),
        .d     (new_smp),
        .q     (taps[k])
      );
    end else begin : g_next
      awmd_cell #(.W(SMP_W)) u_cell (
        .clk   (clk),
        .shift (accept),
        .d     (taps[k-1]),
        .q     (taps[k])
      );
    end
  end

  awmd_frame #(.SAMPLE_BITS(SAMPLE_BITS)) u_frame (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .code_word       (s_axis_tdata),
    .end_of_datagram (s_axis_tlast),
    .taps            (taps),
    .new_smp         (new_smp),
    .push            (push)
  );

  awmd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .room    (room),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .head    (head)
  );

  assign m_axis_tdata = {{PAD_W{1'b0}}, head.sample_number, head.level_half_lsb};
  assign m_axis_tlast = head.datagram_end_out;
  assign m_axis_tuser = {head.run_last, head.over_range_two, head.over_range_one};

endmodule

`default_nettype wire
